// ===== hdl/lfh_pkg.sv =====
package lfh_pkg;

  localparam int NUM_LETTERS  = 26;
  localparam int LETTER_IDX_W = 5;
  localparam int OUT_CNT_W    = 32;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_PTR_W  = 2;
  localparam int QUEUE_CNT_W  = 3;

  localparam logic [7:0] LETTER_LO = 8'h61;
  localparam logic [7:0] LETTER_HI = 8'h7A;

  localparam logic REQ_TEXT   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  typedef struct packed {
    logic                    finish;
    logic [LETTER_IDX_W-1:0] idx;
  } lfh_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_EMIT
  } lfh_bk_state_t;

  typedef struct packed {
    logic cmd_ready;
    logic scan;
    logic emit_load;
    logic emit_last;
  } lfh_bk_ctrl_t;

endpackage

// ===== hdl/letter_frequency_histogram_sorted_core.sv =====
// letter frequency histogram with a sorted report
//
// input channel (in_valid/in_ready): one transaction per text byte or finish.
// in_req_type 0 carries a byte in in_char_byte; 'a'..'z' bump that letter's
// counter and the total, any other byte is dropped. in_req_type 1 is finish.
// output channel (out_valid/out_ready): a finish yields 26 transactions,
// highest count first, equal counts in letter order, out_last_entry on the
// 26th. every entry carries the report's total. counts then restart at zero.
// throughput: one text byte per cycle while the queue has room; a short command
// queue decouples the input from the counter bank. during a finish the counter
// bank finds each entry by one full rotation of the bank through a single
// compare, then loads the entry into the output register.
// the output register lets the next scan run while an entry waits; if the
// receiver stalls, the bank holds and then the queue fills and in_ready drops.
// reset (rst_n low, synchronous) clears all counters, the queue and the
// output register.
module letter_frequency_histogram_sorted_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_req_type,
  input  logic [7:0]                           in_char_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [lfh_pkg::LETTER_IDX_W-1:0]     out_letter_index,
  output logic [lfh_pkg::OUT_CNT_W-1:0]        out_letter_count,
  output logic [lfh_pkg::OUT_CNT_W-1:0]        out_total_letters,
  output logic                                 out_last_entry
);
  import lfh_pkg::*;

  lfh_cmd_t cmd;
  logic     cmd_valid;
  logic     cmd_ready;

  lfh_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_char_byte (in_char_byte),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd)
  );

  lfh_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd_valid),
    .cmd_ready         (cmd_ready),
    .cmd               (cmd),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_letter_index  (out_letter_index),
    .out_letter_count  (out_letter_count),
    .out_total_letters (out_total_letters),
    .out_last_entry    (out_last_entry)
  );

endmodule

// ===== hdl/lfh_front.sv =====
module lfh_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_req_type,
  input  logic [7:0]        in_char_byte,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output lfh_pkg::lfh_cmd_t cmd
);
  import lfh_pkg::*;

  lfh_cmd_t               q_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] cnt_r, cnt_nxt;

  logic     is_fin;
  logic     is_let;
  logic     push;
  logic     pop;
  lfh_cmd_t push_cmd;

  // classify: letters and finish go to the queue, other bytes are dropped here
  always_comb begin
    is_fin          = (in_req_type == REQ_FINISH);
    is_let          = (in_char_byte >= LETTER_LO) && (in_char_byte <= LETTER_HI);
    push            = in_valid && in_ready && (is_fin || is_let);
    push_cmd.finish = is_fin;
    push_cmd.idx    = LETTER_IDX_W'(in_char_byte - LETTER_LO);
  end

  assign in_ready  = (cnt_r != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/lfh_back.sv =====
module lfh_back #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cmd_valid,
  output logic                                 cmd_ready,
  input  lfh_pkg::lfh_cmd_t                    cmd,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [lfh_pkg::LETTER_IDX_W-1:0]     out_letter_index,
  output logic [lfh_pkg::OUT_CNT_W-1:0]        out_letter_count,
  output logic [lfh_pkg::OUT_CNT_W-1:0]        out_total_letters,
  output logic                                 out_last_entry
);
  import lfh_pkg::*;

  localparam logic [LETTER_IDX_W-1:0] LAST_IDX = LETTER_IDX_W'(NUM_LETTERS - 1);

  logic [COUNT_WIDTH-1:0]  cnt_r [NUM_LETTERS];
  logic [NUM_LETTERS-1:0]  done_r;
  logic [COUNT_WIDTH-1:0]  total_r;
  lfh_bk_state_t           state_r, state_nxt;
  logic [LETTER_IDX_W-1:0] pos_r;
  logic [LETTER_IDX_W-1:0] rank_r;
  logic                    best_vld_r;
  logic [COUNT_WIDTH-1:0]  best_cnt_r;
  logic [LETTER_IDX_W-1:0] best_idx_r;

  logic                    out_valid_r;
  logic [LETTER_IDX_W-1:0] out_idx_r;
  logic [OUT_CNT_W-1:0]    out_cnt_r;
  logic [OUT_CNT_W-1:0]    out_total_r;
  logic                    out_last_r;

  lfh_bk_ctrl_t ctrl;
  logic         take;
  logic         slot_free;
  logic         do_inc;

  assign slot_free = !out_valid_r || out_ready;
  assign do_inc    = ctrl.cmd_ready && cmd_valid && !cmd.finish;
  assign take      = ctrl.scan && !done_r[0] && (!best_vld_r || (cnt_r[0] > best_cnt_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid && cmd.finish) begin
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (pos_r == LAST_IDX) begin
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          state_nxt = (rank_r == LAST_IDX) ? BK_IDLE : BK_SCAN;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctrl = '0;
    unique case (state_r)
      BK_IDLE: ctrl.cmd_ready = 1'b1;
      BK_SCAN: ctrl.scan      = 1'b1;
      BK_EMIT: begin
        ctrl.emit_load = slot_free;
        ctrl.emit_last = (rank_r == LAST_IDX);
      end
      default: ctrl = '0;
    endcase
  end

  assign cmd_ready = ctrl.cmd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // counter bank; the scan rotates it one full turn per rank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LETTERS; i++) begin
        cnt_r[i] <= '0;
      end
      done_r  <= '0;
      total_r <= '0;
    end else if (do_inc) begin
      if (cnt_r[cmd.idx] != '1) begin
        cnt_r[cmd.idx] <= cnt_r[cmd.idx] + 1'b1;
      end
      if (total_r != '1) begin
        total_r <= total_r + 1'b1;
      end
    end else if (ctrl.scan) begin
      for (int i = 0; i < NUM_LETTERS - 1; i++) begin
        cnt_r[i] <= cnt_r[i+1];
      end
      cnt_r[NUM_LETTERS-1] <= cnt_r[0];
      done_r <= {done_r[0], done_r[NUM_LETTERS-1:1]};
    end else if (ctrl.emit_load) begin
      if (ctrl.emit_last) begin
        for (int i = 0; i < NUM_LETTERS; i++) begin
          cnt_r[i] <= '0;
        end
        done_r  <= '0;
        total_r <= '0;
      end else begin
        done_r[best_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      rank_r     <= '0;
      best_vld_r <= 1'b0;
    end else if (ctrl.scan) begin
      pos_r <= (pos_r == LAST_IDX) ? '0 : pos_r + 1'b1;
      if (take) begin
        best_vld_r <= 1'b1;
      end
    end else if (ctrl.emit_load) begin
      best_vld_r <= 1'b0;
      rank_r     <= ctrl.emit_last ? '0 : rank_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_cnt_r <= cnt_r[0];
      best_idx_r <= pos_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_load) begin
      out_idx_r   <= best_idx_r;
      out_cnt_r   <= OUT_CNT_W'(best_cnt_r);
      out_total_r <= OUT_CNT_W'(total_r);
      out_last_r  <= ctrl.emit_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_letter_index  = out_idx_r;
  assign out_letter_count  = out_cnt_r;
  assign out_total_letters = out_total_r;
  assign out_last_entry    = out_last_r;

endmodule

// ===== hdl/lfh_checker.sv =====
module lfh_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 in_req_type,
  input logic [7:0]                           in_char_byte,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [lfh_pkg::LETTER_IDX_W-1:0]     out_letter_index,
  input logic [lfh_pkg::OUT_CNT_W-1:0]        out_letter_count,
  input logic [lfh_pkg::OUT_CNT_W-1:0]        out_total_letters,
  input logic                                 out_last_entry
);
  import lfh_pkg::*;

  localparam logic [LETTER_IDX_W-1:0] LAST_IDX = LETTER_IDX_W'(NUM_LETTERS - 1);

  logic [LETTER_IDX_W-1:0] ent_r;
  logic [OUT_CNT_W-1:0]    total_r;
  logic                    out_acc;

  assign out_acc = out_valid && out_ready;

  // position of the next entry within the current report
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else if (out_acc) begin
      ent_r <= out_last_entry ? '0 : ent_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      total_r <= out_total_letters;
    end
  end

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_req_type)
      && $stable(in_char_byte))
    else $error("input transaction changed while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_letter_index)
      && $stable(out_letter_count) && $stable(out_total_letters)
      && $stable(out_last_entry))
    else $error("output transaction changed while stalled");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_entry == (ent_r == LAST_IDX)))
    else $error("last entry flag not on the 26th entry");

  a_total_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (ent_r != '0) |-> (out_total_letters == total_r))
    else $error("total changed within one report");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind letter_frequency_histogram_sorted_core lfh_checker u_lfh_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import lfh_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASE_ITEMS = 120;

  typedef struct {
    logic [LETTER_IDX_W-1:0] idx;
    logic [OUT_CNT_W-1:0]    cnt;
    logic [OUT_CNT_W-1:0]    tot;
    logic                    last;
  } report_entry_t;

  class hist_scoreboard;
    logic [OUT_CNT_W-1:0] counts [NUM_LETTERS];
    logic [OUT_CNT_W-1:0] total;
    report_entry_t        report_q [$];
    int                   errors;

    function new();
      clear_counts();
      errors = 0;
    endfunction

    function void clear_counts();
      foreach (counts[i]) counts[i] = '0;
      total = '0;
    endfunction

    function logic [OUT_CNT_W-1:0] sat_inc(logic [OUT_CNT_W-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    function void note_input(logic req, logic [7:0] ch);
      bit            taken [NUM_LETTERS];
      int            best;
      report_entry_t e;
      if (req == REQ_TEXT) begin
        if (ch >= LETTER_LO && ch <= LETTER_HI) begin
          counts[ch - LETTER_LO] = sat_inc(counts[ch - LETTER_LO]);
          total = sat_inc(total);
        end
        return;
      end
      foreach (taken[i]) taken[i] = 1'b0;
      // highest count first, lowest letter wins a tie
      for (int k = 0; k < NUM_LETTERS; k++) begin
        best = -1;
        for (int i = 0; i < NUM_LETTERS; i++) begin
          if (!taken[i] && (best < 0 || counts[i] > counts[best])) best = i;
        end
        taken[best] = 1'b1;
        e.idx  = best[LETTER_IDX_W-1:0];
        e.cnt  = counts[best];
        e.tot  = total;
        e.last = (k == NUM_LETTERS - 1);
        report_q.push_back(e);
      end
      clear_counts();
    endfunction

    function void compare_field(string name, logic [OUT_CNT_W-1:0] want,
                                logic [OUT_CNT_W-1:0] got);
      if (got !== want) begin
        $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_entry(report_entry_t got);
      report_entry_t want;
      if (report_q.size() == 0) begin
        $display("%0t unexpected transaction: expected none, actual letter %0d count %0d",
                 $time, got.idx, got.cnt);
        $display("%0t   actual total %0d last %0b", $time, got.tot, got.last);
        errors++;
        return;
      end
      want = report_q.pop_front();
      compare_field("letter_index", OUT_CNT_W'(want.idx), OUT_CNT_W'(got.idx));
      compare_field("letter_count", want.cnt, got.cnt);
      compare_field("total_letters", want.tot, got.tot);
      compare_field("last_entry", OUT_CNT_W'(want.last), OUT_CNT_W'(got.last));
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_req_type = REQ_TEXT;
  logic [7:0]              in_char_byte = 8'h00;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [LETTER_IDX_W-1:0] out_letter_index;
  logic [OUT_CNT_W-1:0]    out_letter_count;
  logic [OUT_CNT_W-1:0]    out_total_letters;
  logic                    out_last_entry;

  hist_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  letter_frequency_histogram_sorted_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_char_byte      (in_char_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_letter_index  (out_letter_index),
    .out_letter_count  (out_letter_count),
    .out_total_letters (out_total_letters),
    .out_last_entry    (out_last_entry)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    report_entry_t got;
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_req_type, in_char_byte);
      if (out_valid && out_ready) begin
        got.idx  = out_letter_index;
        got.cnt  = out_letter_count;
        got.tot  = out_total_letters;
        got.last = out_last_entry;
        sb.check_entry(got);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // returns at the edge where the transaction is taken
  task automatic send_item(input logic req, input logic [7:0] ch);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_char_byte <= ch;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random(inout int hot);
    int r;
    r = $urandom_range(99);
    if (r < 4) begin
      send_item(REQ_FINISH, 8'($urandom_range(255)));
      hot = $urandom_range(NUM_LETTERS - 1);
    end else if (r < 14) begin
      send_item(REQ_TEXT, 8'($urandom_range(255)));
    end else if (r < 50) begin
      send_item(REQ_TEXT, 8'(LETTER_LO + hot));
    end else begin
      send_item(REQ_TEXT, 8'(LETTER_LO + $urandom_range(NUM_LETTERS - 1)));
    end
  endtask

  initial begin
    logic [7:0] text_bytes [14] = '{"a", "z", "z", 8'h60, 8'h7B, 8'h00, 8'hFF, 8'h41,
                                    8'h5A, 8'h80, 8'h30, "m", "m", "b"};
    int sender_idle [4] = '{0, 84, 0, 21};
    int receiver_stall [4] = '{0, 0, 84, 21};
    int hot;
    hot = $urandom_range(NUM_LETTERS - 1);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty report, then ties, noise bytes and a cleared second report
    send_item(REQ_FINISH, 8'hFF);
    foreach (text_bytes[i]) send_item(REQ_TEXT, text_bytes[i]);
    send_item(REQ_FINISH, "q");
    send_item(REQ_TEXT, "c");
    send_item(REQ_TEXT, 8'h7F);
    send_item(REQ_FINISH, 8'h00);

    for (int p = 0; p < 4; p++) begin
      idle_pct  = sender_idle[p];
      stall_pct = receiver_stall[p];
      repeat (PHASE_ITEMS) send_random(hot);
      send_item(REQ_FINISH, 8'($urandom_range(255)));
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (sb.report_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
